// ===== rtl/core/rpc_pkg.sv =====
// Shared types, constants and token helpers for the run-length paren-count codec.
package rpc_pkg;

    localparam int MAX_LINE = 1023;
    localparam int LINE_W   = $clog2(MAX_LINE + 1);
    localparam int RUN_W    = 10;
    localparam int ACC_W    = 11;
    localparam int TOTAL_W  = 11;
    localparam int RES_MAX  = 8;
    localparam int RES_N_W  = 4;
    localparam int TOK_MAX  = 8;
    localparam int TOK_N_W  = 3;

    localparam logic [RUN_W-1:0]   RUN_CAP     = 10'd1023;
    localparam logic [TOTAL_W:0]   TOTAL_LIMIT = 12'd1024;
    localparam logic [7:0]         ASCII_ZERO  = 8'd48;
    localparam logic [7:0]         ASCII_NINE  = 8'd57;
    localparam logic [7:0]         OPEN_PAREN  = 8'h28;
    localparam logic [7:0]         CLOSE_PAREN = 8'h29;

    typedef enum logic [1:0] {
        PH_PLAIN  = 2'd0,
        PH_DIGITS = 2'd1,
        PH_CHAR   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [9:0] out_count;
        logic       out_last;
        logic       error;
    } out_t;

    // Results of one input beat, handed from the step logic to the result queue
    typedef struct packed {
        logic [RES_N_W-1:0]    n;
        out_t [RES_MAX-1:0]    item;
    } step_res_t;

    // Byte tokens of one flushed run
    typedef struct packed {
        logic [TOK_N_W-1:0]    n;
        logic [TOK_MAX-1:0][7:0] b;
    } tok_t;

    function automatic logic [15:0] bcd_inc(input logic [15:0] v);
        logic [15:0] r;
        logic        c;
        r = v;
        c = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            if (c)
            begin
                if (v[4*i +: 4] == 4'd9)
                begin
                    r[4*i +: 4] = 4'd0;
                end
                else
                begin
                    r[4*i +: 4] = v[4*i +: 4] + 4'd1;
                    c = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // One or two plain bytes, or '(' digits ')' byte for runs of three and more
    function automatic tok_t flush_tokens(input logic [7:0] ch, input logic [RUN_W-1:0] run,
                                          input logic [15:0] bcd);
        tok_t       t;
        logic [2:0] nd;
        logic [3:0] dg;
        t.n = '0;
        t.b = '0;
        dg  = '0;
        if (bcd[15:12] != 4'd0)
            nd = 3'd4;
        else if (bcd[11:8] != 4'd0)
            nd = 3'd3;
        else if (bcd[7:4] != 4'd0)
            nd = 3'd2;
        else
            nd = 3'd1;
        if (run == RUN_W'(1))
        begin
            t.n    = 3'd1;
            t.b[0] = ch;
        end
        else if (run == RUN_W'(2))
        begin
            t.n    = 3'd2;
            t.b[0] = ch;
            t.b[1] = ch;
        end
        else if (run != '0)
        begin
            t.n = nd + 3'd3;
            for (int k = 0; k < TOK_MAX; k++)
            begin
                if (k == 0)
                begin
                    t.b[k] = OPEN_PAREN;
                end
                else if (k <= int'(nd))
                begin
                    dg     = bcd[4*(int'(nd) - k) +: 4];
                    t.b[k] = ASCII_ZERO + 8'(dg);
                end
                else if (k == int'(nd) + 1)
                begin
                    t.b[k] = CLOSE_PAREN;
                end
                else if (k == int'(nd) + 2)
                begin
                    t.b[k] = ch;
                end
            end
        end
        return t;
    endfunction

endpackage

// ===== rtl/core/rpc_step.sv =====
// Line state registers and the single-pass step logic for pack and unpack.
module rpc_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_mode,
    input  logic               go,
    input  rpc_pkg::in_t       item,
    output rpc_pkg::step_res_t res
);

    logic                          mode_reg, mode_next;
    logic [7:0]                    prev_reg, prev_next;
    logic [rpc_pkg::RUN_W-1:0]     run_reg, run_next;
    logic [15:0]                   bcd_reg, bcd_next;
    logic [rpc_pkg::LINE_W-1:0]    line_reg, line_next;
    rpc_pkg::phase_t               phase_reg, phase_next;
    logic [rpc_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [rpc_pkg::TOTAL_W-1:0]   total_reg, total_next;
    logic                          err_reg, err_next;

    logic [rpc_pkg::LINE_W-1:0]    line_inc;
    logic                          extend;
    logic [rpc_pkg::RUN_W-1:0]     new_run;
    logic [15:0]                   new_bcd;
    rpc_pkg::tok_t                 fa, fb;
    logic [rpc_pkg::TOK_N_W-1:0]   na, nb, j;
    logic                          raise, clear;
    logic                          is_digit;
    logic [14:0]                   acc_mul;
    logic [rpc_pkg::TOTAL_W:0]     sum_char, sum_one;

    always_comb
    begin
        line_inc = (line_reg < rpc_pkg::LINE_W'(rpc_pkg::MAX_LINE)) ?
                   line_reg + rpc_pkg::LINE_W'(1) : line_reg;
        extend   = (run_reg != '0) && (item.in_byte == prev_reg) && (run_reg < rpc_pkg::RUN_CAP);
        new_run  = extend ? run_reg + rpc_pkg::RUN_W'(1) : rpc_pkg::RUN_W'(1);
        new_bcd  = extend ? rpc_pkg::bcd_inc(bcd_reg) : 16'h0001;
        fa       = rpc_pkg::flush_tokens(prev_reg, run_reg, bcd_reg);
        fb       = rpc_pkg::flush_tokens(item.in_byte, new_run, new_bcd);
        na       = extend ? '0 : fa.n;
        nb       = item.in_last ? fb.n : '0;
        is_digit = (item.in_byte >= rpc_pkg::ASCII_ZERO) && (item.in_byte <= rpc_pkg::ASCII_NINE);
        acc_mul  = (15'(acc_reg) << 3) + (15'(acc_reg) << 1) + 15'(item.in_byte[3:0]);
        sum_char = 12'(total_reg) + 12'(acc_reg);
        sum_one  = 12'(total_reg) + 12'd1;
        j        = '0;

        mode_next  = mode_reg;
        prev_next  = prev_reg;
        run_next   = run_reg;
        bcd_next   = bcd_reg;
        line_next  = line_reg;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        total_next = total_reg;
        err_next   = err_reg;
        raise      = 1'b0;
        clear      = 1'b0;
        res        = '0;

        if (cfg_we)
        begin
            mode_next = cfg_mode;
            clear     = 1'b1;
        end
        else if (go)
        begin
            if (err_reg)
            begin
                clear = item.in_last;
            end
            else
            begin
                line_next = line_inc;
                if (line_inc >= rpc_pkg::LINE_W'(rpc_pkg::MAX_LINE))
                begin
                    raise = 1'b1;
                end
                else if (!mode_reg)
                begin
                    prev_next = item.in_byte;
                    run_next  = new_run;
                    bcd_next  = new_bcd;
                    res.n     = rpc_pkg::RES_N_W'(na) + rpc_pkg::RES_N_W'(nb);
                    for (int i = 0; i < rpc_pkg::RES_MAX; i++)
                    begin
                        res.item[i].out_count = 10'd1;
                        if (i < int'(na))
                        begin
                            res.item[i].out_byte = fa.b[i];
                        end
                        else
                        begin
                            j = rpc_pkg::TOK_N_W'(i) - na;
                            res.item[i].out_byte = fb.b[j];
                        end
                    end
                end
                else
                begin
                    unique case (phase_reg)
                        rpc_pkg::PH_DIGITS:
                        begin
                            if (item.in_byte == rpc_pkg::CLOSE_PAREN)
                            begin
                                if (acc_reg == '0 || item.in_last)
                                    raise = 1'b1;
                                else
                                    phase_next = rpc_pkg::PH_CHAR;
                            end
                            else if (is_digit && !item.in_last)
                            begin
                                acc_next = (acc_mul > 15'(rpc_pkg::TOTAL_LIMIT)) ?
                                           rpc_pkg::ACC_W'(rpc_pkg::TOTAL_LIMIT) : acc_mul[10:0];
                            end
                            else
                            begin
                                raise = 1'b1;
                            end
                        end
                        rpc_pkg::PH_CHAR:
                        begin
                            if (sum_char >= rpc_pkg::TOTAL_LIMIT)
                            begin
                                raise = 1'b1;
                            end
                            else
                            begin
                                res.n                    = rpc_pkg::RES_N_W'(1);
                                res.item[0].out_byte     = item.in_byte;
                                res.item[0].out_count    = acc_reg[9:0];
                                total_next               = sum_char[10:0];
                                acc_next                 = '0;
                                phase_next               = rpc_pkg::PH_PLAIN;
                            end
                        end
                        default:
                        begin
                            if (item.in_byte == rpc_pkg::OPEN_PAREN)
                            begin
                                if (item.in_last)
                                begin
                                    raise = 1'b1;
                                end
                                else
                                begin
                                    phase_next = rpc_pkg::PH_DIGITS;
                                    acc_next   = '0;
                                end
                            end
                            else if (sum_one >= rpc_pkg::TOTAL_LIMIT)
                            begin
                                raise = 1'b1;
                            end
                            else
                            begin
                                res.n                 = rpc_pkg::RES_N_W'(1);
                                res.item[0].out_byte  = item.in_byte;
                                res.item[0].out_count = 10'd1;
                                total_next            = sum_one[10:0];
                            end
                        end
                    endcase
                end

                if (raise)
                begin
                    // Error beat ends the line; swallow the rest until the last byte
                    res                    = '0;
                    res.n                  = rpc_pkg::RES_N_W'(1);
                    res.item[0].out_count  = 10'd1;
                    res.item[0].out_last   = 1'b1;
                    res.item[0].error      = 1'b1;
                    clear                  = item.in_last;
                    err_next               = !item.in_last;
                end
                else if (item.in_last)
                begin
                    clear = 1'b1;
                    for (int i = 0; i < rpc_pkg::RES_MAX; i++)
                    begin
                        if (rpc_pkg::RES_N_W'(i) + rpc_pkg::RES_N_W'(1) == res.n)
                            res.item[i].out_last = 1'b1;
                    end
                end
            end
        end

        if (clear)
        begin
            prev_next  = '0;
            run_next   = '0;
            bcd_next   = '0;
            line_next  = '0;
            phase_next = rpc_pkg::PH_PLAIN;
            acc_next   = '0;
            total_next = '0;
            err_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            prev_reg  <= '0;
            run_reg   <= '0;
            bcd_reg   <= '0;
            line_reg  <= '0;
            phase_reg <= rpc_pkg::PH_PLAIN;
            acc_reg   <= '0;
            total_reg <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            prev_reg  <= prev_next;
            run_reg   <= run_next;
            bcd_reg   <= bcd_next;
            line_reg  <= line_next;
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            total_reg <= total_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ===== rtl/core/rpc_outq.sv =====
// Result queue: one beat's results, one out per cycle while out_ready is high.
module rpc_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  rpc_pkg::step_res_t load_res,
    output logic               can_load,
    output logic               out_valid,
    input  logic               out_ready,
    output rpc_pkg::out_t      out_data
);

    rpc_pkg::out_t [rpc_pkg::RES_MAX-1:0] q_reg, q_next;
    logic [rpc_pkg::RES_N_W-1:0]           cnt_reg, cnt_next;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = q_reg[0];

    always_comb
    begin
        can_load = (cnt_reg == '0) || (cnt_reg == rpc_pkg::RES_N_W'(1) && out_ready);
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            q_next   = load_res.item;
            cnt_next = load_res.n;
        end
        else if (out_valid && out_ready)
        begin
            // advance the queue by one beat
            for (int i = 0; i < rpc_pkg::RES_MAX - 1; i++)
            begin
                q_next[i] = q_reg[i+1];
            end
            cnt_next = cnt_reg - rpc_pkg::RES_N_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

endmodule

// ===== rtl/core/rle_paren_count_codec.sv =====
// Top level of the run-length paren-count codec: input register, step logic, result queue.
//
// Input channel (in_valid/in_ready/in_data) takes one character beat per cycle while
// in_ready is high; in_last marks the final character of a line. Output channel
// (out_valid/out_ready/out_data) gives one result beat per cycle while out_ready is
// high. The mode register is written through cfg_valid/cfg_ready/cfg_data (always ready);
// a write also clears all line state, so write it only while the block is idle.
// Mode 0 packs runs of three or more into '(' count ')' byte tokens and leaves shorter
// runs as plain bytes; mode 1 unpacks tokens into byte plus repeat count.
// An accepted character waits in the input register until the step loads its results
// into the result queue. One character per cycle is taken while each gives at most one
// result and out_ready is high. A character that flushes a counted run gives up to 8
// results, which leave the queue one per cycle while out_ready is high; the input
// register then holds the next character until the queue is down to its last beat.
// Reset clears mode to pack, the line state, the input register and the queue.
// When the receiver stalls, the queue holds its head beat, and once the input
// register is also occupied in_ready drops.
module rle_paren_count_codec (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rpc_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output rpc_pkg::out_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data
);

    logic               a_valid_reg, a_valid_next;
    rpc_pkg::in_t       a_item_reg;
    logic               can_load;
    logic               step_go;
    rpc_pkg::step_res_t step_res;

    // The step fires when the queue can take the whole result set of the held beat
    assign step_go   = a_valid_reg && can_load;
    assign in_ready  = !a_valid_reg || can_load;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_valid && in_ready)
            a_valid_next = 1'b1;
        else if (step_go)
            a_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    // Hold the payload until the step consumes it
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            a_item_reg <= in_data;
    end

    rpc_step u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_mode (cfg_data),
        .go       (step_go),
        .item     (a_item_reg),
        .res      (step_res)
    );

    rpc_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step_go),
        .load_res  (step_res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> a_valid_reg)
        else $error("accepted beat not held in input register");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !step_go |=> a_valid_reg && $stable(a_item_reg))
        else $error("held input beat lost while queue busy");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error |-> out_data.out_last)
        else $error("error result not marked as end of line");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.out_count != 10'd0)
        else $error("result with zero repeat count");

endmodule
